// ===== rtl/ucoi_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 character offset indexer.
package ucoi_pkg;

  localparam int MAX_BYTES_DEF = 65536;
  localparam int FIELD_W       = 17;
  localparam int LEVELS        = 17;
  localparam int LVL_W         = 5;
  localparam int QDEPTH        = 4;
  localparam int QAW           = $clog2(QDEPTH);

  localparam logic [1:0] KIND_START    = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_INVALID  = 2'd2;
  localparam logic [1:0] KIND_CAPACITY = 2'd3;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [LEVELS-1:0][FIELD_W-1:0] lvl_arr_t;

  typedef struct packed {
    logic       start_vld;
    field_t     start_num;
    field_t     start_off;
    field_t     start_base;
    logic       close_vld;
    field_t     close_num;
    field_t     close_off;
    field_t     close_base;
    logic [1:0] close_kind;
  } rec_t;

  function automatic logic [LVL_W-1:0] lowest_level(input field_t v);
    logic [LVL_W-1:0] r;
    r = LVL_W'(LEVELS);
    for (int b = LEVELS - 1; b >= 0; b--) begin
      if (v[b]) begin
        r = LVL_W'(b);
      end
    end
    return r;
  endfunction

  function automatic field_t tree_base(input logic mode, input field_t num,
                                       input lvl_arr_t arr);
    field_t           parent;
    logic [LVL_W-1:0] lv;
    parent = num & (num - 1'b1);
    lv     = lowest_level(parent);
    if (!mode || parent == '0 || lv >= LVL_W'(LEVELS)) begin
      return '0;
    end
    return arr[lv];
  endfunction

endpackage

// ===== rtl/utf8_char_offset_indexer.sv =====
// Top level of the UTF-8 character offset indexer.
// Input channel: one string byte per word (in_text_byte) with in_final_byte marking
// the last byte of a string. Output channel: one index entry per word, giving the
// character number, its start offset (or prefix difference when tree mode is set),
// the entry kind and a flag on the last entry caused by a byte.
// cfg_wr_en/cfg_wr_data load the tree mode bit; write it only while the block is idle.
// Path: a byte's entry record is written into the record queue and then loaded into the
// output register. Throughput: one byte per cycle while the queue has room; a byte that
// yields both a character start and a closing entry gives two output words, start first.
// The front end takes one byte per cycle as long as the four-record queue has room;
// a stalled receiver fills the output register, then the queue, then drops in_ready.
// Reset clears the string state, the prefix offsets, the queue and tree mode.
// Bytes beyond MAX_BYTES in one string end it with a capacity entry.
module utf8_char_offset_indexer #(
  parameter int MAX_BYTES = ucoi_pkg::MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_entry_number,
  output logic [16:0] out_entry_value,
  output logic [1:0]  out_entry_kind,
  output logic        out_run_last
);

  logic           push, q_full, pop, head_vld;
  ucoi_pkg::rec_t push_rec, head_rec;

  ucoi_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .push          (push),
    .push_rec      (push_rec)
  );

  ucoi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .head_vld (head_vld),
    .head_rec (head_rec)
  );

  ucoi_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_vld         (head_vld),
    .head_rec         (head_rec),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_entry_number (out_entry_number),
    .out_entry_value  (out_entry_value),
    .out_entry_kind   (out_entry_kind),
    .out_run_last     (out_run_last)
  );

endmodule

// ===== rtl/ucoi_front.sv =====
// Front end: accepts bytes, classifies lead bytes and builds per-byte entry records.
module ucoi_front #(
  parameter int MAX_BYTES = ucoi_pkg::MAX_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_text_byte,
  input  logic            in_final_byte,
  input  logic            q_full,
  output logic            push,
  output ucoi_pkg::rec_t  push_rec
);

  localparam int PW = $clog2(MAX_BYTES + 1);
  localparam int OW = $clog2(MAX_BYTES + 4);
  localparam int FW = ucoi_pkg::FIELD_W;
  localparam int LW = ucoi_pkg::LVL_W;

  logic                 tree_mode_r;
  logic [PW-1:0]        pos_r, pos_nxt, cnt_r, cnt_nxt, cnt_after;
  logic [OW-1:0]        ns_r, ns_nxt, ns_after;
  logic [1:0]           skip_r, skip_nxt;
  logic                 stopped_r, stopped_nxt;
  ucoi_pkg::lvl_arr_t   prefix_r, prefix_fwd;

  logic                 acc, is_nul, is_bad, start_now, close_now, stop_now;
  logic [2:0]           len;
  logic [1:0]           close_kind;
  logic [LW-1:0]        lv_w;
  ucoi_pkg::field_t     cnt17, ns17, close_num;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign cnt17    = FW'(cnt_r);
  assign ns17     = FW'(ns_r);
  assign lv_w     = ucoi_pkg::lowest_level(cnt17);

  assign is_nul = (in_text_byte == 8'h00);
  assign is_bad = (in_text_byte[7:6] == 2'b10) || (in_text_byte[7:3] == 5'b11111);

  always_comb begin
    priority if (!in_text_byte[7]) begin
      len = 3'd1;
    end else if (in_text_byte[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (in_text_byte[7:4] == 4'b1110) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    skip_nxt   = skip_r;
    cnt_after  = cnt_r;
    ns_after   = ns_r;
    start_now  = 1'b0;
    close_now  = 1'b0;
    stop_now   = 1'b0;
    close_kind = ucoi_pkg::KIND_END;
    if (acc && !stopped_r) begin
      if (pos_r >= PW'(MAX_BYTES)) begin
        close_now  = 1'b1;
        close_kind = ucoi_pkg::KIND_CAPACITY;
        stop_now   = 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (skip_r != 2'd0) begin
          skip_nxt = skip_r - 2'd1;
        end else if (is_nul) begin
          close_now  = 1'b1;
          close_kind = ucoi_pkg::KIND_END;
          stop_now   = 1'b1;
        end else if (is_bad) begin
          close_now  = 1'b1;
          close_kind = ucoi_pkg::KIND_INVALID;
          stop_now   = 1'b1;
        end else begin
          start_now = 1'b1;
          cnt_after = cnt_r + 1'b1;
          ns_after  = ns_r + OW'(len);
          skip_nxt  = 2'(len - 3'd1);
        end
        if (in_final_byte && !stop_now) begin
          close_now  = 1'b1;
          close_kind = ucoi_pkg::KIND_END;
        end
      end
    end
    cnt_nxt     = cnt_after;
    ns_nxt      = ns_after;
    stopped_nxt = stopped_r | stop_now;
    if (acc && in_final_byte) begin
      pos_nxt     = '0;
      ns_nxt      = '0;
      skip_nxt    = 2'd0;
      cnt_nxt     = '0;
      stopped_nxt = 1'b0;
    end
  end

  // forward this byte's prefix write to its own closing entry
  always_comb begin
    prefix_fwd = prefix_r;
    if (start_now && lv_w < LW'(ucoi_pkg::LEVELS)) begin
      prefix_fwd[lv_w] = ns17;
    end
  end

  assign close_num = FW'(cnt_after);

  always_comb begin
    push_rec            = '0;
    push_rec.start_vld  = start_now;
    push_rec.start_num  = cnt17;
    push_rec.start_off  = ns17;
    push_rec.start_base = ucoi_pkg::tree_base(tree_mode_r, cnt17, prefix_r);
    push_rec.close_vld  = close_now;
    push_rec.close_num  = close_num;
    push_rec.close_off  = FW'(ns_after);
    push_rec.close_base = ucoi_pkg::tree_base(tree_mode_r, close_num, prefix_fwd);
    push_rec.close_kind = close_kind;
  end

  assign push = start_now || close_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_mode_r <= 1'b0;
      pos_r       <= '0;
      ns_r        <= '0;
      skip_r      <= 2'd0;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      prefix_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        tree_mode_r <= cfg_wr_data;
      end
      pos_r     <= pos_nxt;
      ns_r      <= ns_nxt;
      skip_r    <= skip_nxt;
      cnt_r     <= cnt_nxt;
      stopped_r <= stopped_nxt;
      prefix_r  <= prefix_fwd;
    end
  end

endmodule

// ===== rtl/ucoi_queue.sv =====
// Short record queue between the front end and the output stage.
module ucoi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ucoi_pkg::rec_t  push_rec,
  output logic            full,
  input  logic            pop,
  output logic            head_vld,
  output ucoi_pkg::rec_t  head_rec
);

  localparam int AW = ucoi_pkg::QAW;
  localparam int CW = ucoi_pkg::QAW + 1;

  ucoi_pkg::rec_t mem_r [ucoi_pkg::QDEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(ucoi_pkg::QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_rec = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/ucoi_back.sv =====
// Back end: expands queued records into output words and applies the tree difference.
module ucoi_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_vld,
  input  ucoi_pkg::rec_t        head_rec,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [16:0]           out_entry_number,
  output logic [16:0]           out_entry_value,
  output logic [1:0]            out_entry_kind,
  output logic                  out_run_last
);

  logic             out_valid_r, second_r, load, emit_close;
  logic [16:0]      num_r, val_r;
  logic [1:0]       kind_r;
  logic             last_r;

  assign load       = !out_valid_r || out_ready;
  assign emit_close = !head_rec.start_vld || second_r;

  always_comb begin
    pop = 1'b0;
    if (head_vld && load) begin
      pop = emit_close || !head_rec.close_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_vld) begin
      if (emit_close) begin
        num_r  <= head_rec.close_num;
        val_r  <= head_rec.close_off - head_rec.close_base;
        kind_r <= head_rec.close_kind;
        last_r <= 1'b1;
      end else begin
        num_r  <= head_rec.start_num;
        val_r  <= head_rec.start_off - head_rec.start_base;
        kind_r <= ucoi_pkg::KIND_START;
        last_r <= !head_rec.close_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_vld;
      if (head_vld) begin
        second_r <= !emit_close && head_rec.close_vld;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_entry_number = num_r;
  assign out_entry_value  = val_r;
  assign out_entry_kind   = kind_r;
  assign out_run_last     = last_r;

endmodule
